/* rtl/bqc_pkg.sv */
package bqc_pkg;

  // Character codes the scanner reacts to
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Opener kind codes held in each stack entry
  localparam int unsigned KIND_BITS = 3;
  typedef logic [KIND_BITS-1:0] open_kind_t;
  localparam open_kind_t KIND_PAREN  = 3'd0;
  localparam open_kind_t KIND_SQUARE = 3'd1;
  localparam open_kind_t KIND_BRACE  = 3'd2;
  localparam open_kind_t KIND_DQUOTE = 3'd3;
  localparam open_kind_t KIND_SQUOTE = 3'd4;

  // Report kinds on the result channel
  typedef enum logic [1:0] {
    REP_UNMATCHED = 2'd0,
    REP_UNCLOSED  = 2'd1,
    REP_FULL      = 2'd2,
    REP_CLEAN     = 2'd3
  } rep_kind_t;

  // Shift command broadcast along the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } bqc_shift_t;

  function automatic logic [7:0] kind_char(input open_kind_t k);
    logic [7:0] ch;
    unique case (k)
      KIND_PAREN:  ch = CH_LPAREN;
      KIND_SQUARE: ch = CH_LSQ;
      KIND_BRACE:  ch = CH_LBRACE;
      KIND_DQUOTE: ch = CH_DQUOTE;
      KIND_SQUOTE: ch = CH_SQUOTE;
      default:     ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/bqc_cell.sv */
module bqc_cell
  import bqc_pkg::*;
#(
  parameter int unsigned LINE_BITS = 16
) (
  input  logic                 clk,
  input  bqc_shift_t           shift,
  input  open_kind_t           above_kind,
  input  logic [LINE_BITS-1:0] above_line,
  input  open_kind_t           below_kind,
  input  logic [LINE_BITS-1:0] below_line,
  output open_kind_t           kind,
  output logic [LINE_BITS-1:0] line
);

  open_kind_t           kind_r, kind_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  // Push takes the entry from above, pop the entry from below
  always_comb begin
    kind_nxt = kind_r;
    line_nxt = line_r;
    if (shift.push) begin
      kind_nxt = above_kind;
      line_nxt = above_line;
    end else if (shift.pop) begin
      kind_nxt = below_kind;
      line_nxt = below_line;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    line_r <= line_nxt;
  end

  assign kind = kind_r;
  assign line = line_r;

endmodule

/* rtl/bracket_quote_comment_checker.sv */
// Bracket, quote and comment checker: one source byte per beat.
// A report is registered: it appears on the output register in the cycle after the beat that causes it.
// Throughput: one byte per cycle; input stalls only while a report waits untaken.
// The open stack is a chain of STACK_DEPTH cells that all shift in the same cycle.
// Reset (rst_n low, synchronous) empties the stack, sets the line counter to one and
// clears the comment, string and pending flags; an end-of-text beat does the same.
module bracket_quote_comment_checker
  import bqc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned LINE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] report_char, [23:8] report_line
  output logic [1:0]  out_tuser   // [1:0] report_kind
);

  localparam int unsigned CNT_BITS = $clog2(STACK_DEPTH + 1);

  // Scanner state
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 comment_r, comment_nxt;
  logic                 string_r, string_nxt;
  logic                 slash_r, slash_nxt;
  logic                 star_r, star_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  rep_kind_t            out_kind_r, out_kind_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic [15:0]          out_line_r, out_line_nxt;

  // Cell chain
  open_kind_t           cell_kind [STACK_DEPTH];
  logic [LINE_BITS-1:0] cell_line [STACK_DEPTH];
  bqc_shift_t           shift;
  open_kind_t           push_kind;

  logic       accept;
  logic [7:0] ch;
  logic       quiet;
  logic       have_top;
  logic       stack_full;
  logic       do_push;
  logic       rep_valid;
  rep_kind_t  rep_kind;
  logic [7:0] rep_char;
  logic [15:0] rep_line;

  // Take a new byte whenever the output register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign ch        = in_tdata;
  assign have_top  = (count_r != '0);
  assign stack_full = (count_r == CNT_BITS'(STACK_DEPTH));

  always_comb begin
    count_nxt   = count_r;
    line_nxt    = line_r;
    comment_nxt = comment_r;
    string_nxt  = string_r;
    slash_nxt   = slash_r;
    star_nxt    = star_r;
    shift       = '0;
    push_kind   = KIND_PAREN;
    do_push     = 1'b0;
    rep_valid   = 1'b0;
    rep_kind    = REP_CLEAN;
    rep_char    = 8'h00;
    rep_line    = 16'h0000;
    quiet       = comment_r || string_r;

    if (accept) begin
      if (in_tlast) begin
        // End of text: report the top opener or a clean end, then start over
        rep_valid = 1'b1;
        if (have_top) begin
          rep_kind = REP_UNCLOSED;
          rep_char = kind_char(cell_kind[0]);
          rep_line = 16'(cell_line[0]);
        end
        count_nxt   = '0;
        line_nxt    = LINE_BITS'(1);
        comment_nxt = 1'b0;
        string_nxt  = 1'b0;
        slash_nxt   = 1'b0;
        star_nxt    = 1'b0;
      end else if (slash_r && ch == CH_STAR) begin
        // Slash then star: open a block comment and consume the star
        slash_nxt   = 1'b0;
        comment_nxt = 1'b1;
      end else if (star_r && ch == CH_SLASH) begin
        // Star then slash inside a comment: close it and consume the slash
        slash_nxt   = 1'b0;
        star_nxt    = 1'b0;
        comment_nxt = 1'b0;
      end else begin
        slash_nxt = 1'b0;
        star_nxt  = 1'b0;
        unique case (ch)
          CH_NL: begin
            if (line_r != '1) line_nxt = line_r + LINE_BITS'(1);
          end
          CH_DQUOTE: begin
            if (!comment_r) begin
              if (string_r) begin
                string_nxt = 1'b0;
                if (have_top && cell_kind[0] == KIND_DQUOTE) shift.pop = 1'b1;
              end else begin
                string_nxt = 1'b1;
                push_kind  = KIND_DQUOTE;
                do_push    = 1'b1;
              end
            end
          end
          CH_SQUOTE: begin
            if (!quiet) begin
              if (have_top && cell_kind[0] == KIND_SQUOTE) begin
                shift.pop = 1'b1;
              end else begin
                push_kind = KIND_SQUOTE;
                do_push   = 1'b1;
              end
            end
          end
          CH_SLASH: begin
            if (!quiet) slash_nxt = 1'b1;
          end
          CH_STAR: begin
            if (comment_r && !string_r) star_nxt = 1'b1;
          end
          CH_LPAREN, CH_LSQ, CH_LBRACE: begin
            if (!quiet) begin
              do_push = 1'b1;
              if (ch == CH_LPAREN)   push_kind = KIND_PAREN;
              else if (ch == CH_LSQ) push_kind = KIND_SQUARE;
              else                   push_kind = KIND_BRACE;
            end
          end
          CH_RPAREN, CH_RSQ, CH_RBRACE: begin
            if (!quiet) begin
              if (have_top &&
                  ((ch == CH_RPAREN && cell_kind[0] == KIND_PAREN) ||
                   (ch == CH_RSQ    && cell_kind[0] == KIND_SQUARE) ||
                   (ch == CH_RBRACE && cell_kind[0] == KIND_BRACE))) begin
                shift.pop = 1'b1;
              end else begin
                rep_valid = 1'b1;
                rep_kind  = REP_UNMATCHED;
                rep_char  = ch;
                rep_line  = 16'(line_r);
              end
            end
          end
          default: ;
        endcase

        // Push into the chain, or drop it and report a full stack
        if (do_push) begin
          if (stack_full) begin
            rep_valid = 1'b1;
            rep_kind  = REP_FULL;
            rep_char  = kind_char(push_kind);
            rep_line  = 16'(line_r);
          end else begin
            shift.push = 1'b1;
          end
        end
        if (shift.push) count_nxt = count_r + CNT_BITS'(1);
        if (shift.pop)  count_nxt = count_r - CNT_BITS'(1);
      end
    end
  end

  // Output register: load on accept, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_line_nxt  = out_line_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (accept) begin
      out_valid_nxt = rep_valid;
      out_kind_nxt  = rep_kind;
      out_char_nxt  = rep_char;
      out_line_nxt  = rep_line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      line_r      <= LINE_BITS'(1);
      comment_r   <= 1'b0;
      string_r    <= 1'b0;
      slash_r     <= 1'b0;
      star_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      line_r      <= line_nxt;
      comment_r   <= comment_nxt;
      string_r    <= string_nxt;
      slash_r     <= slash_nxt;
      star_r      <= star_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_line_r <= out_line_nxt;
  end

  // Stack cells: cell 0 is the top, new entries enter there
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    open_kind_t           a_kind, b_kind;
    logic [LINE_BITS-1:0] a_line, b_line;
    if (i == 0) begin : g_top
      assign a_kind = push_kind;
      assign a_line = line_r;
    end else begin : g_mid
      assign a_kind = cell_kind[i-1];
      assign a_line = cell_line[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign b_kind = KIND_PAREN;
      assign b_line = '0;
    end else begin : g_up
      assign b_kind = cell_kind[i+1];
      assign b_line = cell_line[i+1];
    end
    bqc_cell #(.LINE_BITS(LINE_BITS)) u_cell (
      .clk        (clk),
      .shift      (shift),
      .above_kind (a_kind),
      .above_line (a_line),
      .below_kind (b_kind),
      .below_line (b_line),
      .kind       (cell_kind[i]),
      .line       (cell_line[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_line_r, out_char_r};
  assign out_tuser  = out_kind_r;

endmodule

/* rtl/bqc_checker.sv */
module bqc_checker
  import bqc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled report holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("report changed while stalled");

  // Every end-of-text beat yields a report in the next cycle
  a_eot_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no report after end of text");

  // With no report pending the input is always ready
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A clean end carries no character and no line
  a_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REP_CLEAN |-> out_tdata == 24'h000000)
    else $error("clean end with payload");

  // Reset leaves the output empty
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("report after reset");

endmodule

bind bracket_quote_comment_checker bqc_checker u_bqc_checker (.*);
